[hw/rtl/alct_pkg.sv]
// Shared types, constants and register codes of the alive counter timestamp checker.
package alct_pkg;

	localparam int NUM_CHANNELS_DEF = 16;
	localparam int CH_W             = 4;
	localparam int CFG_IDX_W        = 4;
	localparam int CFG_DATA_W       = 32;
	localparam int CNT_W            = 16;
	localparam int STAMP_W          = 32;
	localparam int DEB_W            = 29;
	localparam int BOUND_W          = 33;
	localparam int STUCK_W          = 8;
	localparam int MASK_W           = 16;

	localparam logic [STUCK_W-1:0] STUCK_SAT = 8'd255;

	localparam logic [CNT_W-1:0]   RST_MAX_WRAP_STEP = 16'd2;
	localparam logic [STUCK_W-1:0] RST_MAX_CONST     = 8'd2;
	localparam logic [CNT_W-1:0]   RST_COUNTER_MAX   = 16'hFFFF;
	localparam logic [STAMP_W-1:0] RST_STAMP_MAX     = 32'hFFFF_FFFF;
	localparam logic [DEB_W-1:0]   RST_DEBOUNCE      = 29'd100;
	localparam logic [BOUND_W-1:0] RST_WIDE_BOUND    = 33'd1000;
	localparam logic [MASK_W-1:0]  RST_MASK          = 16'hFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_WRAP_STEP = 4'd0,
		REG_MAX_CONST     = 4'd1,
		REG_COUNTER_MAX   = 4'd2,
		REG_STAMP_MAX     = 4'd3,
		REG_DEBOUNCE      = 4'd4,
		REG_MC_MASK       = 4'd5,
		REG_TS_MASK       = 4'd6,
		REG_CC_MASK       = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic               round_start;
		logic [CH_W-1:0]    channel;
		logic               present;
		logic [CNT_W-1:0]   cycle_count;
		logic [CNT_W-1:0]   meas_count;
		logic [STAMP_W-1:0] stamp;
		logic [STAMP_W-1:0] base_stamp;
	} in_t;

	typedef struct packed {
		logic       meas_fail;
		logic       stamp_back_fail;
		logic       stamp_old_fail;
		logic       cycle_back_fail;
		logic       cycle_stuck_fail;
		logic [2:0] alive_error;
	} out_t;

	typedef struct packed {
		logic [CNT_W-1:0]   max_wrap_step;
		logic [STUCK_W-1:0] max_constant_items;
		logic [CNT_W-1:0]   counter_max;
		logic [STAMP_W-1:0] timestamp_max;
		logic [DEB_W-1:0]   debounce_time;
		logic [BOUND_W-1:0] wide_bound;
		logic [MASK_W-1:0]  mc_check_mask;
		logic [MASK_W-1:0]  ts_check_mask;
		logic [MASK_W-1:0]  cc_check_mask;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0]   cycle;
		logic [CNT_W-1:0]   meas;
		logic [STAMP_W-1:0] stamp;
		logic [STUCK_W-1:0] stuck;
	} chan_t;

endpackage

[hw/rtl/alct_cfg.sv]
// Configuration register file with the precomputed timestamp wrap bound.
module alct_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [alct_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [alct_pkg::CFG_DATA_W-1:0]    cfg_data,
	output alct_pkg::cfg_t                     cfg
);

	alct_pkg::cfg_t cfg_q;
	logic [alct_pkg::BOUND_W-1:0] deb_ext;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;
	assign deb_ext   = alct_pkg::BOUND_W'(cfg_data[alct_pkg::DEB_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_wrap_step      <= alct_pkg::RST_MAX_WRAP_STEP;
			cfg_q.max_constant_items <= alct_pkg::RST_MAX_CONST;
			cfg_q.counter_max        <= alct_pkg::RST_COUNTER_MAX;
			cfg_q.timestamp_max      <= alct_pkg::RST_STAMP_MAX;
			cfg_q.debounce_time      <= alct_pkg::RST_DEBOUNCE;
			cfg_q.wide_bound         <= alct_pkg::RST_WIDE_BOUND;
			cfg_q.mc_check_mask      <= alct_pkg::RST_MASK;
			cfg_q.ts_check_mask      <= alct_pkg::RST_MASK;
			cfg_q.cc_check_mask      <= alct_pkg::RST_MASK;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				alct_pkg::REG_MAX_WRAP_STEP: begin
					cfg_q.max_wrap_step <= cfg_data[alct_pkg::CNT_W-1:0];
				end
				alct_pkg::REG_MAX_CONST: begin
					cfg_q.max_constant_items <= cfg_data[alct_pkg::STUCK_W-1:0];
				end
				alct_pkg::REG_COUNTER_MAX: begin
					cfg_q.counter_max <= cfg_data[alct_pkg::CNT_W-1:0];
				end
				alct_pkg::REG_STAMP_MAX: begin
					cfg_q.timestamp_max <= cfg_data[alct_pkg::STAMP_W-1:0];
				end
				alct_pkg::REG_DEBOUNCE: begin
					cfg_q.debounce_time <= cfg_data[alct_pkg::DEB_W-1:0];
					cfg_q.wide_bound    <= (deb_ext << 3) + (deb_ext << 1);
				end
				alct_pkg::REG_MC_MASK: begin
					cfg_q.mc_check_mask <= cfg_data[alct_pkg::MASK_W-1:0];
				end
				alct_pkg::REG_TS_MASK: begin
					cfg_q.ts_check_mask <= cfg_data[alct_pkg::MASK_W-1:0];
				end
				alct_pkg::REG_CC_MASK: begin
					cfg_q.cc_check_mask <= cfg_data[alct_pkg::MASK_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[hw/rtl/alct_chan_store.sv]
// Per-channel history registers: previous counters, timestamp and stuck count.
module alct_chan_store #(
	parameter int NUM_CHANNELS = alct_pkg::NUM_CHANNELS_DEF,
	parameter int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IDX_W-1:0]  idx,
	output alct_pkg::chan_t   rd,
	input  logic              wr_en,
	input  alct_pkg::chan_t   wr
);

	alct_pkg::chan_t hist_q [NUM_CHANNELS];

	assign rd = hist_q[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				hist_q[i] <= '0;
			end
		end else if (wr_en) begin
			hist_q[idx] <= wr;
		end
	end

endmodule

[hw/rtl/alct_check.sv]
// Counter and timestamp checks of one request against its channel history.
module alct_check #(
	parameter int NUM_CHANNELS = alct_pkg::NUM_CHANNELS_DEF
) (
	input  alct_pkg::in_t   item,
	input  alct_pkg::chan_t prev,
	input  alct_pkg::cfg_t  cfg,
	input  logic [2:0]      round_error,
	output logic            in_range,
	output logic            upd,
	output alct_pkg::chan_t next,
	output alct_pkg::out_t  res,
	output logic [2:0]      round_error_next
);

	localparam int CW = alct_pkg::CNT_W + 2;
	localparam int SW = alct_pkg::STAMP_W + 2;

	logic mc_en, ts_en, cc_en;
	logic signed [CW-1:0] step_meas, step_cyc, bound_cnt;
	logic signed [SW-1:0] step_back, step_old, bound_ts;
	logic [alct_pkg::STAMP_W-1:0] base_min;
	logic f_meas, f_back, f_old, f_cback, f_stuck;
	logic cyc_wrap_far;
	logic [alct_pkg::STUCK_W-1:0] stuck_inc;
	logic [2:0] err_bits, err_base;

	assign in_range = ({1'b0, item.channel} < (alct_pkg::CH_W + 1)'(NUM_CHANNELS));
	assign upd      = item.present && (item.channel != '0) && in_range;

	assign mc_en = cfg.mc_check_mask[item.channel];
	assign ts_en = cfg.ts_check_mask[item.channel];
	assign cc_en = cfg.cc_check_mask[item.channel];

	assign bound_cnt = $signed(CW'(cfg.max_wrap_step));
	assign bound_ts  = $signed(SW'(cfg.wide_bound));

	assign step_meas = $signed(CW'(cfg.counter_max) - CW'(prev.meas) + CW'(item.meas_count));
	assign step_cyc  = $signed(CW'(cfg.counter_max) - CW'(prev.cycle) + CW'(item.cycle_count));
	assign step_back = $signed(SW'(cfg.timestamp_max) - SW'(prev.stamp) + SW'(item.stamp));
	assign step_old  = $signed(SW'(cfg.timestamp_max) - SW'(item.base_stamp) + SW'(item.stamp));
	assign base_min  = item.base_stamp - alct_pkg::STAMP_W'(cfg.debounce_time);

	assign cyc_wrap_far = step_cyc > bound_cnt;
	assign stuck_inc    = (prev.stuck == alct_pkg::STUCK_SAT) ? prev.stuck : prev.stuck + 8'd1;

	always_comb begin
		f_meas  = upd && mc_en && (item.meas_count < prev.meas) && (step_meas > bound_cnt);
		f_back  = upd && ts_en && (item.stamp < prev.stamp) && (step_back > bound_ts);
		f_old   = upd && ts_en
			&& (item.base_stamp > alct_pkg::STAMP_W'(cfg.debounce_time))
			&& (item.stamp < base_min) && (step_old > bound_ts);
		f_cback = 1'b0;
		f_stuck = 1'b0;

		next.cycle = item.cycle_count;
		next.meas  = item.meas_count;
		next.stamp = item.stamp;
		next.stuck = prev.stuck;

		if (upd && cc_en) begin
			if (item.cycle_count < prev.cycle) begin
				if (cyc_wrap_far) begin
					f_cback = 1'b1;
				end else begin
					next.stuck = '0;
				end
			end else if (item.cycle_count == prev.cycle) begin
				next.stuck = stuck_inc;
				f_stuck    = stuck_inc > cfg.max_constant_items;
			end else begin
				next.stuck = '0;
			end
		end

		err_bits = {f_cback || f_stuck, f_back || f_old, f_meas};
		err_base = item.round_start ? 3'b000 : round_error;
		round_error_next = err_base | err_bits;

		res.meas_fail        = f_meas;
		res.stamp_back_fail  = f_back;
		res.stamp_old_fail   = f_old;
		res.cycle_back_fail  = f_cback;
		res.cycle_stuck_fail = f_stuck;
		res.alive_error      = round_error_next;
	end

endmodule

[hw/rtl/alct_stage.sv]
// Input and result registers with the per-request advance control.
module alct_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  alct_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output alct_pkg::out_t out_data,
	output alct_pkg::in_t  item_s1,
	output logic           adv,
	input  alct_pkg::out_t res
);

	logic           valid_s1;
	alct_pkg::in_t  data_s1;
	logic           valid_s2;
	alct_pkg::out_t data_s2;

	assign adv       = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign item_s1   = data_s1;
	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
		if (adv) begin
			data_s2 <= res;
		end
	end

`ifndef SYNTHESIS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input blocked with empty input stage");
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(data_s1))
		else $error("stalled request lost from input stage");
	a_fill_s2: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2 && (data_s2 == $past(res)))
		else $error("result register not loaded on advance");
`endif

endmodule

[hw/rtl/alive_counter_timestamp_checker.sv]
// Top level of the alive counter and timestamp checker.
//
// Each request on the in channel carries one channel header: round_start,
// channel, present, cycle and measurement counters, timestamp and the base
// timestamp. For every request exactly one result leaves on the out channel
// with five failure flags and the alive error gathered over the round.
// Channel 0, channels at or above NUM_CHANNELS and absent headers give no
// failures and leave the channel history alone.
// The request is held in the input stage and its result in the result register.
// Throughput: one request per cycle while the receiver takes results; the channel
// history is read, checked and written back as the request moves from the input
// stage to the result register.
// When the receiver stalls, the result register holds and the next request
// waits in the input stage; in_ready drops only while both are full.
// Configuration writes on the cfg channel are always taken and must happen
// while no request is in flight.
// Reset clears the history, the round error and loads the register defaults.
module alive_counter_timestamp_checker #(
	parameter int NUM_CHANNELS = alct_pkg::NUM_CHANNELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  alct_pkg::in_t                   in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output alct_pkg::out_t                  out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [alct_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [alct_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	alct_pkg::cfg_t  cfg;
	alct_pkg::in_t   item_s1;
	alct_pkg::chan_t prev;
	alct_pkg::chan_t next;
	alct_pkg::out_t  res;
	logic            adv;
	logic            in_range;
	logic            upd;
	logic [IDX_W-1:0] idx;
	logic [2:0]      round_error_q;
	logic [2:0]      round_error_next;

	assign idx = in_range ? item_s1.channel[IDX_W-1:0] : '0;

	alct_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	alct_stage u_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.item_s1   (item_s1),
		.adv       (adv),
		.res       (res)
	);

	alct_chan_store #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.IDX_W        (IDX_W)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.idx    (idx),
		.rd     (prev),
		.wr_en  (adv && upd),
		.wr     (next)
	);

	alct_check #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_check (
		.item             (item_s1),
		.prev             (prev),
		.cfg              (cfg),
		.round_error      (round_error_q),
		.in_range         (in_range),
		.upd              (upd),
		.next             (next),
		.res              (res),
		.round_error_next (round_error_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_error_q <= '0;
		end else if (adv) begin
			round_error_q <= round_error_next;
		end
	end

`ifndef SYNTHESIS
	a_base_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !upd |=> !out_data.meas_fail && !out_data.stamp_back_fail
			&& !out_data.stamp_old_fail && !out_data.cycle_back_fail
			&& !out_data.cycle_stuck_fail)
		else $error("failure flagged for unchecked channel");
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !item_s1.round_start
			|=> (out_data.alive_error & $past(round_error_q)) == $past(round_error_q))
		else $error("round error lost bits within a round");
	a_error_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_data.alive_error == round_error_q)
		else $error("reported alive error differs from round error");
`endif

endmodule
